// ===== src/bme_pkg.sv =====
// ----------------------------------------------------------------------------
// bme_pkg: shared types and constants of the bilinear mesh evaluator
// Holds fixed-point widths, multiplier operation codes, configuration
// register indexes and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package bme_pkg;

   // Fixed-point formats.
   localparam int FRAC_W  = 16;              // Fraction bits of a Q1.16 parameter.
   localparam int PARAM_W = 17;              // Q1.16 parameter, 65536 means 1.0.
   localparam int COORD_W = 32;              // Signed Q16.16 coordinate.
   localparam int MUL_A_W = 33;              // Weight operand, up to 2^32.
   localparam int MUL_B_W = 32;              // Biased coordinate operand.
   localparam int ACC_W   = 64;              // Exact weighted sum.

   localparam logic [PARAM_W-1:0] ONE_Q16   = 17'h1_0000;
   localparam logic [COORD_W-1:0] SIGN_FLIP = 32'h8000_0000;
   localparam logic [ACC_W-1:0]   RND_HALF  = 64'h0000_0000_8000_0000;

   // Item actions.
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_EVAL  = 1'b1;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_U = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_V = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_U   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_V   = 2'd3;

   // Operations of the shared multiplier; the datapath also uses the code,
   // delayed through a register, to steer the product to its destination.
   typedef logic [3:0] op_type;
   localparam op_type OP_NONE = 4'd0;
   localparam op_type OP_LOCU = 4'd1;
   localparam op_type OP_LOCV = 4'd2;
   localparam op_type OP_W0   = 4'd3;
   localparam op_type OP_W1   = 4'd4;
   localparam op_type OP_W2   = 4'd5;
   localparam op_type OP_W3   = 4'd6;
   localparam op_type OP_MX   = 4'd7;
   localparam op_type OP_MY   = 4'd8;
   localparam op_type OP_MZ   = 4'd9;

   typedef struct packed {
      logic       wr_en;       // Store the control point of the accepted item.
      logic       start;       // Latch u and v, clear the sums.
      op_type     op;          // Multiplier operation this cycle.
      logic [1:0] corner;      // Corner whose weight feeds a blend product.
      logic       rd_en;       // Read one corner from the grid.
      logic [1:0] rd_corner;   // Corner to read.
      logic       load_out;    // Round the sums into the output register.
   } cmd_type;

endpackage

// ===== src/bme_ram.sv =====
// ----------------------------------------------------------------------------
// bme_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bme_datapath.sv =====
// ----------------------------------------------------------------------------
// bme_datapath: grid storage and arithmetic of the mesh evaluator
// Holds the configuration registers, the three coordinate grids, one shared
// multiplier with its product register, the corner indexes, the weights,
// the sums and the output register.
// ----------------------------------------------------------------------------
module bme_datapath #(
   parameter int MAX_POINTS_U = 64,
   parameter int MAX_POINTS_V = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  bme_pkg::cmd_type                        cmd,
   input  logic                                    csr_wr,
   input  logic [bme_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [bme_pkg::CSR_DAT_W-1:0]           csr_wdata,
   input  logic [5:0]                              req_column,
   input  logic [5:0]                              req_row,
   input  logic signed [bme_pkg::COORD_W-1:0]      req_point_x,
   input  logic signed [bme_pkg::COORD_W-1:0]      req_point_y,
   input  logic signed [bme_pkg::COORD_W-1:0]      req_point_z,
   input  logic [bme_pkg::PARAM_W-1:0]             req_param_u,
   input  logic [bme_pkg::PARAM_W-1:0]             req_param_v,
   output logic signed [bme_pkg::COORD_W-1:0]      rsp_surf_x,
   output logic signed [bme_pkg::COORD_W-1:0]      rsp_surf_y,
   output logic signed [bme_pkg::COORD_W-1:0]      rsp_surf_z
);

   localparam int EUW_U = $clog2(MAX_POINTS_U + 1);
   localparam int EUW_V = $clog2(MAX_POINTS_V + 1);
   localparam int IUW_U = $clog2(MAX_POINTS_U);
   localparam int IUW_V = $clog2(MAX_POINTS_V);
   localparam int DEPTH = MAX_POINTS_U * MAX_POINTS_V;
   localparam int AW    = $clog2(DEPTH);

   // Configuration.
   logic [bme_pkg::CSR_DAT_W-1:0] points_u_ff;
   logic [bme_pkg::CSR_DAT_W-1:0] points_v_ff;
   logic                          wrap_u_ff;
   logic                          wrap_v_ff;

   // Evaluation state.
   logic [bme_pkg::PARAM_W-1:0]   pu_ff;
   logic [bme_pkg::PARAM_W-1:0]   pv_ff;
   logic [bme_pkg::ACC_W-1:0]     prod_ff;
   bme_pkg::op_type               dst_ff;
   logic [IUW_U-1:0]              u0_ff;
   logic [IUW_U-1:0]              u1_ff;
   logic [IUW_V-1:0]              v0_ff;
   logic [IUW_V-1:0]              v1_ff;
   logic [bme_pkg::PARAM_W-1:0]   fu_ff;
   logic [bme_pkg::PARAM_W-1:0]   fv_ff;
   logic [bme_pkg::MUL_A_W-1:0]   w_ff [4];
   logic [bme_pkg::ACC_W-1:0]     acc_x_ff;
   logic [bme_pkg::ACC_W-1:0]     acc_y_ff;
   logic [bme_pkg::ACC_W-1:0]     acc_z_ff;
   logic [bme_pkg::COORD_W-1:0]   surf_x_ff;
   logic [bme_pkg::COORD_W-1:0]   surf_y_ff;
   logic [bme_pkg::COORD_W-1:0]   surf_z_ff;

   // Combinational signals.
   logic [EUW_U-1:0]              nu;
   logic [EUW_V-1:0]              nv;
   logic [EUW_U-1:0]              npu;
   logic [EUW_V-1:0]              npv;
   logic [EUW_U-1:0]              idx_u;
   logic [EUW_V-1:0]              idx_v;
   logic [EUW_U:0]                nxt_u;
   logic [EUW_V:0]                nxt_v;
   logic [bme_pkg::PARAM_W-1:0]   fr_u;
   logic [bme_pkg::PARAM_W-1:0]   fr_v;
   logic [bme_pkg::MUL_A_W-1:0]   mul_a;
   logic [bme_pkg::MUL_B_W-1:0]   mul_b;
   logic [bme_pkg::MUL_A_W+bme_pkg::MUL_B_W-1:0] mul_full;
   logic                          wr_ok;
   logic [AW-1:0]                 wr_addr;
   logic [AW-1:0]                 rd_addr;
   logic [IUW_U-1:0]              rd_u;
   logic [IUW_V-1:0]              rd_v;
   logic [bme_pkg::COORD_W-1:0]   rd_x;
   logic [bme_pkg::COORD_W-1:0]   rd_y;
   logic [bme_pkg::COORD_W-1:0]   rd_z;

   function automatic logic [bme_pkg::COORD_W-1:0] round_sum(
      input logic [bme_pkg::ACC_W-1:0] sum
   );
      logic [bme_pkg::ACC_W-1:0] biased;
      biased = sum + bme_pkg::RND_HALF;
      return biased[bme_pkg::ACC_W-1 -: bme_pkg::COORD_W] ^ bme_pkg::SIGN_FLIP;
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         points_u_ff <= bme_pkg::CSR_DAT_W'(2);
         points_v_ff <= bme_pkg::CSR_DAT_W'(2);
         wrap_u_ff   <= 1'b0;
         wrap_v_ff   <= 1'b0;
      end else if (csr_wr) begin
         case (csr_index)
            bme_pkg::CSR_POINTS_U: points_u_ff <= csr_wdata;
            bme_pkg::CSR_POINTS_V: points_v_ff <= csr_wdata;
            bme_pkg::CSR_WRAP_U:   wrap_u_ff   <= csr_wdata[0];
            bme_pkg::CSR_WRAP_V:   wrap_v_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective point and patch counts.
   always_comb begin
      if (points_u_ff < bme_pkg::CSR_DAT_W'(2)) begin
         nu = EUW_U'(2);
      end else if (32'(points_u_ff) > MAX_POINTS_U) begin
         nu = EUW_U'(MAX_POINTS_U);
      end else begin
         nu = EUW_U'(points_u_ff);
      end
      if (points_v_ff < bme_pkg::CSR_DAT_W'(2)) begin
         nv = EUW_V'(2);
      end else if (32'(points_v_ff) > MAX_POINTS_V) begin
         nv = EUW_V'(MAX_POINTS_V);
      end else begin
         nv = EUW_V'(points_v_ff);
      end
      npu = wrap_u_ff ? nu : nu - EUW_U'(1);
      npv = wrap_v_ff ? nv : nv - EUW_V'(1);
   end

   // Patch location from the product of parameter and patch count.
   always_comb begin
      idx_u = prod_ff[bme_pkg::FRAC_W +: EUW_U];
      fr_u  = {1'b0, prod_ff[bme_pkg::FRAC_W-1:0]};
      if (idx_u >= npu) begin
         idx_u = npu - EUW_U'(1);
         fr_u  = bme_pkg::ONE_Q16;
      end
      nxt_u = {1'b0, idx_u} + (EUW_U + 1)'(1);
      if (nxt_u >= {1'b0, nu}) begin
         nxt_u = '0;
      end

      idx_v = prod_ff[bme_pkg::FRAC_W +: EUW_V];
      fr_v  = {1'b0, prod_ff[bme_pkg::FRAC_W-1:0]};
      if (idx_v >= npv) begin
         idx_v = npv - EUW_V'(1);
         fr_v  = bme_pkg::ONE_Q16;
      end
      nxt_v = {1'b0, idx_v} + (EUW_V + 1)'(1);
      if (nxt_v >= {1'b0, nv}) begin
         nxt_v = '0;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (cmd.op)
         bme_pkg::OP_LOCU: begin
            mul_a = bme_pkg::MUL_A_W'(npu);
            mul_b = bme_pkg::MUL_B_W'(pu_ff);
         end
         bme_pkg::OP_LOCV: begin
            mul_a = bme_pkg::MUL_A_W'(npv);
            mul_b = bme_pkg::MUL_B_W'(pv_ff);
         end
         bme_pkg::OP_W0: begin
            mul_a = bme_pkg::MUL_A_W'(bme_pkg::ONE_Q16 - fu_ff);
            mul_b = bme_pkg::MUL_B_W'(bme_pkg::ONE_Q16 - fv_ff);
         end
         bme_pkg::OP_W1: begin
            mul_a = bme_pkg::MUL_A_W'(fu_ff);
            mul_b = bme_pkg::MUL_B_W'(bme_pkg::ONE_Q16 - fv_ff);
         end
         bme_pkg::OP_W2: begin
            mul_a = bme_pkg::MUL_A_W'(bme_pkg::ONE_Q16 - fu_ff);
            mul_b = bme_pkg::MUL_B_W'(fv_ff);
         end
         bme_pkg::OP_W3: begin
            mul_a = bme_pkg::MUL_A_W'(fu_ff);
            mul_b = bme_pkg::MUL_B_W'(fv_ff);
         end
         bme_pkg::OP_MX: begin
            mul_a = w_ff[cmd.corner];
            mul_b = rd_x ^ bme_pkg::SIGN_FLIP;
         end
         bme_pkg::OP_MY: begin
            mul_a = w_ff[cmd.corner];
            mul_b = rd_y ^ bme_pkg::SIGN_FLIP;
         end
         bme_pkg::OP_MZ: begin
            mul_a = w_ff[cmd.corner];
            mul_b = rd_z ^ bme_pkg::SIGN_FLIP;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_full = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dst_ff <= bme_pkg::OP_NONE;
      end else begin
         dst_ff <= cmd.op;
      end
   end

   // The product lands in the cycle after its operation and is steered by the
   // delayed operation code.
   always_ff @(posedge clock) begin
      prod_ff <= mul_full[bme_pkg::ACC_W-1:0];
      if (cmd.start) begin
         pu_ff    <= (req_param_u > bme_pkg::ONE_Q16) ? bme_pkg::ONE_Q16 : req_param_u;
         pv_ff    <= (req_param_v > bme_pkg::ONE_Q16) ? bme_pkg::ONE_Q16 : req_param_v;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         acc_z_ff <= '0;
      end else begin
         case (dst_ff)
            bme_pkg::OP_LOCU: begin
               u0_ff <= idx_u[IUW_U-1:0];
               u1_ff <= nxt_u[IUW_U-1:0];
               fu_ff <= fr_u;
            end
            bme_pkg::OP_LOCV: begin
               v0_ff <= idx_v[IUW_V-1:0];
               v1_ff <= nxt_v[IUW_V-1:0];
               fv_ff <= fr_v;
            end
            bme_pkg::OP_W0: w_ff[0] <= prod_ff[bme_pkg::MUL_A_W-1:0];
            bme_pkg::OP_W1: w_ff[1] <= prod_ff[bme_pkg::MUL_A_W-1:0];
            bme_pkg::OP_W2: w_ff[2] <= prod_ff[bme_pkg::MUL_A_W-1:0];
            bme_pkg::OP_W3: w_ff[3] <= prod_ff[bme_pkg::MUL_A_W-1:0];
            bme_pkg::OP_MX: acc_x_ff <= acc_x_ff + prod_ff;
            bme_pkg::OP_MY: acc_y_ff <= acc_y_ff + prod_ff;
            bme_pkg::OP_MZ: acc_z_ff <= acc_z_ff + prod_ff;
            default: ;
         endcase
      end
      if (cmd.load_out) begin
         surf_x_ff <= round_sum(acc_x_ff);
         surf_y_ff <= round_sum(acc_y_ff);
         surf_z_ff <= round_sum(acc_z_ff);
      end
   end

   // Grid addressing: row * MAX_POINTS_U + column.
   assign wr_ok   = (32'(req_column) < MAX_POINTS_U) && (32'(req_row) < MAX_POINTS_V);
   assign wr_addr = AW'(req_row) * AW'(MAX_POINTS_U) + AW'(req_column);
   assign rd_u    = cmd.rd_corner[0] ? u1_ff : u0_ff;
   assign rd_v    = cmd.rd_corner[1] ? v1_ff : v0_ff;
   assign rd_addr = AW'(rd_v) * AW'(MAX_POINTS_U) + AW'(rd_u);

   bme_ram #(.WIDTH(bme_pkg::COORD_W), .DEPTH(DEPTH)) u_grid_x (
      .clock   (clock),
      .wr_en   (cmd.wr_en && wr_ok),
      .wr_addr (wr_addr),
      .wr_data ($unsigned(req_point_x)),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_x)
   );

   bme_ram #(.WIDTH(bme_pkg::COORD_W), .DEPTH(DEPTH)) u_grid_y (
      .clock   (clock),
      .wr_en   (cmd.wr_en && wr_ok),
      .wr_addr (wr_addr),
      .wr_data ($unsigned(req_point_y)),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_y)
   );

   bme_ram #(.WIDTH(bme_pkg::COORD_W), .DEPTH(DEPTH)) u_grid_z (
      .clock   (clock),
      .wr_en   (cmd.wr_en && wr_ok),
      .wr_addr (wr_addr),
      .wr_data ($unsigned(req_point_z)),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_z)
   );

   assign rsp_surf_x = $signed(surf_x_ff);
   assign rsp_surf_y = $signed(surf_y_ff);
   assign rsp_surf_z = $signed(surf_z_ff);

endmodule

// ===== src/bme_ctrl.sv =====
// ----------------------------------------------------------------------------
// bme_ctrl: sequencer of the mesh evaluator
// Accepts items, steps the shared multiplier through location, weights and
// blend products, and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module bme_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_action,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bme_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOCU  = 3'd1;
   localparam logic [2:0] S_LOCV  = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_WGT   = 3'd4;
   localparam logic [2:0] S_BLEND = 3'd5;
   localparam logic [2:0] S_FLUSH = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] coord_ff, coord_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      coord_in  = coord_ff;
      cmd       = '0;
      cmd.op    = bme_pkg::OP_NONE;
      req_stall = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == bme_pkg::ACTION_EVAL) begin
                  cmd.start = 1'b1;
                  state_in  = S_LOCU;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         S_LOCU: begin
            cmd.op   = bme_pkg::OP_LOCU;
            state_in = S_LOCV;
         end
         S_LOCV: begin
            cmd.op   = bme_pkg::OP_LOCV;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            cnt_in   = 2'd0;
            state_in = S_WGT;
         end
         S_WGT: begin
            case (cnt_ff)
               2'd0:    cmd.op = bme_pkg::OP_W0;
               2'd1:    cmd.op = bme_pkg::OP_W1;
               2'd2:    cmd.op = bme_pkg::OP_W2;
               default: cmd.op = bme_pkg::OP_W3;
            endcase
            if (cnt_ff == 2'd3) begin
               cmd.rd_en     = 1'b1;
               cmd.rd_corner = 2'd0;
               cnt_in        = 2'd0;
               coord_in      = 2'd0;
               state_in      = S_BLEND;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         S_BLEND: begin
            cmd.corner = cnt_ff;
            case (coord_ff)
               2'd0:    cmd.op = bme_pkg::OP_MX;
               2'd1:    cmd.op = bme_pkg::OP_MY;
               2'd2:    cmd.op = bme_pkg::OP_MZ;
               default: cmd.op = bme_pkg::OP_NONE;
            endcase
            if (coord_ff == 2'd2) begin
               coord_in = 2'd0;
               if (cnt_ff == 2'd3) begin
                  state_in = S_FLUSH;
               end else begin
                  cmd.rd_en     = 1'b1;
                  cmd.rd_corner = cnt_ff + 2'd1;
                  cnt_in        = cnt_ff + 2'd1;
               end
            end else begin
               coord_in = coord_ff + 2'd1;
            end
         end
         S_FLUSH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 2'd0;
         coord_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         coord_ff     <= coord_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/bilinear_mesh_eval.sv =====
// A write item is taken while the block is idle and leaves it idle. An evaluate
// item keeps the block busy until its result is loaded into the output register;
// only then is the next item taken. Its length is set by the 18 operations that
// share the one multiplier and the four corner reads through the one read port.
// Reset is synchronous and active high; it restores the configuration defaults and
// empties the output register. Grid contents are undefined until written.
// ----------------------------------------------------------------------------
// bilinear_mesh_eval: bilinear patch mesh evaluator
// Stores a grid of 3D control points and blends the four corners of the patch
// that holds (u, v) into one surface point in signed Q16.16.
// ----------------------------------------------------------------------------
module bilinear_mesh_eval #(
   parameter int MAX_POINTS_U = 64,
   parameter int MAX_POINTS_V = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,

   // Item input channel.
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_action,
   input  logic [5:0]                              req_column,
   input  logic [5:0]                              req_row,
   input  logic signed [bme_pkg::COORD_W-1:0]      req_point_x,
   input  logic signed [bme_pkg::COORD_W-1:0]      req_point_y,
   input  logic signed [bme_pkg::COORD_W-1:0]      req_point_z,
   input  logic [bme_pkg::PARAM_W-1:0]             req_param_u,
   input  logic [bme_pkg::PARAM_W-1:0]             req_param_v,

   // Result channel.
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [bme_pkg::COORD_W-1:0]      rsp_surf_x,
   output logic signed [bme_pkg::COORD_W-1:0]      rsp_surf_y,
   output logic signed [bme_pkg::COORD_W-1:0]      rsp_surf_z,

   // Configuration write channel.
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [bme_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [bme_pkg::CSR_DAT_W-1:0]           csr_wdata
);

   // The controller sequences one evaluate item at a time. In the idle state
   // it takes an item every cycle: a write item stores its point into the
   // three coordinate grids at once and leaves the block idle, while an
   // evaluate item starts the sequence below.
   //
   //   LOCU, LOCV  The multiplier forms param * patch_count for each
   //               direction; the integer part is the patch, the fraction
   //               the local coordinate, clamped at the top end.
   //   WAIT        The second location product settles into its registers.
   //   WGT x4      The four corner weights, each a Q1.32 product.
   //   BLEND x12   For each corner, its x, y and z (sign-biased) times its
   //               weight, summed exactly in 64-bit accumulators. A corner
   //               is read from the grid while the last product of the
   //               previous corner is formed.
   //   FLUSH       The last product reaches its accumulator.
   //   DONE        The sums are rounded into the output register as soon as
   //               it is free, and the block returns to idle.
   //
   // The output register keeps a finished result while the block goes on
   // to accept the next item.
   bme_pkg::cmd_type cmd;

   // Configuration is written only while the block is idle, a rule that binds the
   // user and that the block does not enforce, so the port can always be ready.
   assign csr_ready = 1'b1;

   bme_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd)
   );

   bme_datapath #(
      .MAX_POINTS_U (MAX_POINTS_U),
      .MAX_POINTS_V (MAX_POINTS_V)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .csr_wr      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_column  (req_column),
      .req_row     (req_row),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .req_param_u (req_param_u),
      .req_param_v (req_param_v),
      .rsp_surf_x  (rsp_surf_x),
      .rsp_surf_y  (rsp_surf_y),
      .rsp_surf_z  (rsp_surf_z)
   );

endmodule

// ===== src/bme_checker.sv =====
// ----------------------------------------------------------------------------
// bme_checker: port-level assertions for the mesh evaluator
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module bme_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic                                    req_action,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic signed [bme_pkg::COORD_W-1:0]      rsp_surf_x,
   input  logic signed [bme_pkg::COORD_W-1:0]      rsp_surf_y,
   input  logic signed [bme_pkg::COORD_W-1:0]      rsp_surf_z
);

   // A stalled result stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_surf_x)
                                  && $stable(rsp_surf_y) && $stable(rsp_surf_z))
      else $error("result changed while stalled");

   // An accepted evaluate item makes the block busy in the next cycle.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == bme_pkg::ACTION_EVAL |=> req_stall)
      else $error("block not busy after an evaluate item");

   // A write item leaves the block free for the next item.
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == bme_pkg::ACTION_WRITE |=> !req_stall)
      else $error("block busy after a write item");

   // A new result appears together with the return to idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result presented while still busy");

endmodule

bind bilinear_mesh_eval bme_checker u_bme_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_action (req_action),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_surf_x (rsp_surf_x),
   .rsp_surf_y (rsp_surf_y),
   .rsp_surf_z (rsp_surf_z)
);

// ===== tb/bilinear_mesh_eval_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_mesh_eval_check: scoreboard of the bilinear mesh evaluator
// Watches the item, result and register channels, keeps its own control
// point grid and register copies, predicts each surface point and compares it
// with the result that the block returns.
// ----------------------------------------------------------------------------
module bilinear_mesh_eval_check #(
   parameter int MAX_POINTS_U = 64,
   parameter int MAX_POINTS_V = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic                                    req_action,
   input  logic [5:0]                              req_column,
   input  logic [5:0]                              req_row,
   input  logic signed [bme_pkg::COORD_W-1:0]      req_point_x,
   input  logic signed [bme_pkg::COORD_W-1:0]      req_point_y,
   input  logic signed [bme_pkg::COORD_W-1:0]      req_point_z,
   input  logic [bme_pkg::PARAM_W-1:0]             req_param_u,
   input  logic [bme_pkg::PARAM_W-1:0]             req_param_v,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic signed [bme_pkg::COORD_W-1:0]      rsp_surf_x,
   input  logic signed [bme_pkg::COORD_W-1:0]      rsp_surf_y,
   input  logic signed [bme_pkg::COORD_W-1:0]      rsp_surf_z,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [bme_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [bme_pkg::CSR_DAT_W-1:0]           csr_wdata,
   output int                                      mismatch_count,
   output int                                      results_owed
);

   typedef struct packed {
      logic [bme_pkg::COORD_W-1:0] x;
      logic [bme_pkg::COORD_W-1:0] y;
      logic [bme_pkg::COORD_W-1:0] z;
   } coord3_type;

   coord3_type                      mesh [MAX_POINTS_U*MAX_POINTS_V];
   coord3_type                      surface_q [$];
   logic [bme_pkg::CSR_DAT_W-1:0]   reg_points_u = 7'd2;
   logic [bme_pkg::CSR_DAT_W-1:0]   reg_points_v = 7'd2;
   logic                            reg_wrap_u = 1'b0;
   logic                            reg_wrap_v = 1'b0;
   int                              errors = 0;

   function automatic int unsigned clamp_points(input logic [bme_pkg::CSR_DAT_W-1:0] r,
                                                input int unsigned limit);
      if (r < 2) return 2;
      if (32'(r) > limit) return limit;
      return 32'(r);
   endfunction

   // Patch index, second corner and local fraction of one parameter.
   function automatic void split_param(input logic [bme_pkg::PARAM_W-1:0] p,
                                       input int unsigned pts, input logic wrap,
                                       output int unsigned i0, output int unsigned i1,
                                       output logic [bme_pkg::PARAM_W-1:0] frac);
      int unsigned npatch;
      int unsigned pc;
      int unsigned prod;
      int unsigned idx;
      npatch = wrap ? pts : pts - 1;
      pc = (p > bme_pkg::ONE_Q16) ? 32'(bme_pkg::ONE_Q16) : 32'(p);
      prod = pc * npatch;
      idx = prod >> bme_pkg::FRAC_W;
      frac = {1'b0, prod[bme_pkg::FRAC_W-1:0]};
      if (idx >= npatch) begin
         idx = npatch - 1;
         frac = bme_pkg::ONE_Q16;
      end
      i0 = idx;
      i1 = (idx + 1 >= pts) ? 0 : idx + 1;
   endfunction

   // The sum is taken over sign-flipped coordinates so that it stays unsigned.
   function automatic logic [bme_pkg::COORD_W-1:0] blend_corners(
         input logic [3:0][bme_pkg::COORD_W-1:0] corners,
         input logic [3:0][bme_pkg::ACC_W-1:0] weights);
      logic [bme_pkg::ACC_W-1:0] acc;
      int k;
      acc = '0;
      for (k = 0; k < 4; k++)
         acc += bme_pkg::ACC_W'(corners[k] ^ bme_pkg::SIGN_FLIP) * weights[k];
      acc = (acc + bme_pkg::RND_HALF) >> 32;
      return acc[bme_pkg::COORD_W-1:0] ^ bme_pkg::SIGN_FLIP;
   endfunction

   function automatic coord3_type predict_surface(input logic [bme_pkg::PARAM_W-1:0] pu,
                                                  input logic [bme_pkg::PARAM_W-1:0] pv);
      int unsigned u0, u1, v0, v1;
      logic [bme_pkg::PARAM_W-1:0] fu, fv;
      int unsigned addr [4];
      logic [3:0][bme_pkg::ACC_W-1:0] wt;
      logic [3:0][bme_pkg::COORD_W-1:0] cx, cy, cz;
      coord3_type s;
      int k;
      split_param(pu, clamp_points(reg_points_u, MAX_POINTS_U), reg_wrap_u, u0, u1, fu);
      split_param(pv, clamp_points(reg_points_v, MAX_POINTS_V), reg_wrap_v, v0, v1, fv);
      addr[0] = v0 * MAX_POINTS_U + u0;
      addr[1] = v0 * MAX_POINTS_U + u1;
      addr[2] = v1 * MAX_POINTS_U + u0;
      addr[3] = v1 * MAX_POINTS_U + u1;
      wt[0] = bme_pkg::ACC_W'(bme_pkg::ONE_Q16 - fu) * bme_pkg::ACC_W'(bme_pkg::ONE_Q16 - fv);
      wt[1] = bme_pkg::ACC_W'(fu) * bme_pkg::ACC_W'(bme_pkg::ONE_Q16 - fv);
      wt[2] = bme_pkg::ACC_W'(bme_pkg::ONE_Q16 - fu) * bme_pkg::ACC_W'(fv);
      wt[3] = bme_pkg::ACC_W'(fu) * bme_pkg::ACC_W'(fv);
      for (k = 0; k < 4; k++) begin
         cx[k] = mesh[addr[k]].x;
         cy[k] = mesh[addr[k]].y;
         cz[k] = mesh[addr[k]].z;
      end
      s.x = blend_corners(cx, wt);
      s.y = blend_corners(cy, wt);
      s.z = blend_corners(cz, wt);
      return s;
   endfunction

   always @(posedge clock) begin
      coord3_type got;
      coord3_type want;
      if (reset) begin
         reg_points_u = 7'd2;
         reg_points_v = 7'd2;
         reg_wrap_u = 1'b0;
         reg_wrap_v = 1'b0;
         surface_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bme_pkg::CSR_POINTS_U: reg_points_u = csr_wdata;
               bme_pkg::CSR_POINTS_V: reg_points_v = csr_wdata;
               bme_pkg::CSR_WRAP_U:   reg_wrap_u = csr_wdata[0];
               bme_pkg::CSR_WRAP_V:   reg_wrap_v = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_action == bme_pkg::ACTION_WRITE) begin
               if (req_column < MAX_POINTS_U && req_row < MAX_POINTS_V)
                  mesh[req_row * MAX_POINTS_U + req_column] =
                     {req_point_x, req_point_y, req_point_z};
            end else begin
               surface_q.push_back(predict_surface(req_param_u, req_param_v));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_surf_x, rsp_surf_y, rsp_surf_z};
            if (surface_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: surface result with none expected: x=%h y=%h z=%h",
                           $realtime, got.x, got.y, got.z);
            end else begin
               want = surface_q.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: surface mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                              $realtime, want.x, want.y, want.z, got.x, got.y, got.z);
               end
            end
         end
      end
      mismatch_count <= errors;
      results_owed <= surface_q.size();
   end

endmodule

// ===== tb/bilinear_mesh_eval_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_mesh_eval_test: top of the bilinear mesh evaluator testbench
// Loads control points, sweeps the grid size and wrap registers through their
// extremes and evaluates the surface at edge and random parameters, with
// random idling on both channels and one long result hold-off. A separate
// scoreboard predicts and checks every surface point.
// ----------------------------------------------------------------------------
module bilinear_mesh_eval_test;

   localparam int GRID_U = 64;
   localparam int GRID_V = 64;
   // Extra margin, once every evaluation has come back, before registers
   // change.
   localparam int SETTLE_CYCLES = 30;
   localparam int PHASE_ITEMS = 20;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_action;
   logic [5:0]             req_column;
   logic [5:0]             req_row;
   logic signed [bme_pkg::COORD_W-1:0] req_point_x;
   logic signed [bme_pkg::COORD_W-1:0] req_point_y;
   logic signed [bme_pkg::COORD_W-1:0] req_point_z;
   logic [bme_pkg::PARAM_W-1:0]     req_param_u;
   logic [bme_pkg::PARAM_W-1:0]     req_param_v;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic signed [bme_pkg::COORD_W-1:0] rsp_surf_x;
   logic signed [bme_pkg::COORD_W-1:0] rsp_surf_y;
   logic signed [bme_pkg::COORD_W-1:0] rsp_surf_z;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [bme_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [bme_pkg::CSR_DAT_W-1:0]   csr_wdata;

   int                     fail_total;
   int                     results_owed;

   // Grid entries that hold a written point. Evaluations only ever touch the
   // active rectangle, and that rectangle is always filled in before use.
   bit                     filled [GRID_U*GRID_V];
   int unsigned            span_u;
   int unsigned            span_v;

   // Flags shared with the result side; they are set with nonblocking
   // assignments so the receiver always sees them one step later.
   bit                     steady = 1'b0;
   bit                     squeeze_now = 1'b0;

   // Register settings of the random phases: points_u, points_v, wrap_u,
   // wrap_v. Out-of-range counts (0, 1, 65, 127) are mixed in on purpose.
   int phase_cfg [8][4] = '{
      '{3, 5, 0, 1}, '{127, 0, 1, 0}, '{1, 64, 0, 1}, '{64, 2, 1, 1},
      '{7, 9, 0, 0}, '{65, 2, 0, 1}, '{6, 6, 1, 0}, '{5, 4, 1, 1}
   };

   bilinear_mesh_eval #(
      .MAX_POINTS_U (GRID_U),
      .MAX_POINTS_V (GRID_V)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_column  (req_column),
      .req_row     (req_row),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .req_param_u (req_param_u),
      .req_param_v (req_param_v),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_surf_x  (rsp_surf_x),
      .rsp_surf_y  (rsp_surf_y),
      .rsp_surf_z  (rsp_surf_z),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   bilinear_mesh_eval_check #(
      .MAX_POINTS_U (GRID_U),
      .MAX_POINTS_V (GRID_V)
   ) i_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_column     (req_column),
      .req_row        (req_row),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .req_param_u    (req_param_u),
      .req_param_v    (req_param_v),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_surf_x     (rsp_surf_x),
      .rsp_surf_y     (rsp_surf_y),
      .rsp_surf_z     (rsp_surf_z),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (fail_total),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A coordinate that hits the extremes of the signed range now and then.
   function automatic logic [bme_pkg::COORD_W-1:0] pick_coord();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // A parameter, mostly inside [0, 1], with the ends, the value just below
   // one and an occasional value above one, which the block treats as one.
   function automatic logic [bme_pkg::PARAM_W-1:0] pick_param();
      case ($urandom_range(19))
         0: return '0;
         1: return bme_pkg::ONE_Q16;
         2: return bme_pkg::ONE_Q16 - 17'd1;
         3: return bme_pkg::PARAM_W'($urandom_range(131071, 65537));
         default: return bme_pkg::PARAM_W'($urandom_range(65536));
      endcase
   endfunction

   // Offers one item at a falling edge and returns at the rising edge that
   // takes it. Valid stays high afterwards so back-to-back items need no gap;
   // the next call either replaces the payload or drops valid for an idle.
   task automatic send_item(input logic act, input logic [5:0] col, input logic [5:0] row,
                            input logic [bme_pkg::COORD_W-1:0] px,
                            input logic [bme_pkg::COORD_W-1:0] py,
                            input logic [bme_pkg::COORD_W-1:0] pz,
                            input logic [bme_pkg::PARAM_W-1:0] pu,
                            input logic [bme_pkg::PARAM_W-1:0] pv);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 9) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_action = act;
      req_column = col;
      req_row = row;
      req_point_x = px;
      req_point_y = py;
      req_point_z = pz;
      req_param_u = pu;
      req_param_v = pv;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (act == bme_pkg::ACTION_WRITE)
         filled[row * GRID_U + col] = 1'b1;
   endtask

   task automatic write_point(input logic [5:0] col, input logic [5:0] row,
                              input logic [bme_pkg::COORD_W-1:0] px,
                              input logic [bme_pkg::COORD_W-1:0] py,
                              input logic [bme_pkg::COORD_W-1:0] pz);
      send_item(bme_pkg::ACTION_WRITE, col, row, px, py, pz,
                bme_pkg::PARAM_W'($urandom), bme_pkg::PARAM_W'($urandom));
   endtask

   // Evaluation items carry random junk in the fields that only writes use.
   task automatic evaluate(input logic [bme_pkg::PARAM_W-1:0] pu,
                           input logic [bme_pkg::PARAM_W-1:0] pv);
      send_item(bme_pkg::ACTION_EVAL, 6'($urandom), 6'($urandom), $urandom, $urandom,
                $urandom, pu, pv);
   endtask

   // Makes sure every point that the active grid size can read holds data.
   task automatic fill_region();
      int unsigned r, c;
      for (r = 0; r < span_v; r++)
         for (c = 0; c < span_u; c++)
            if (!filled[r * GRID_U + c])
               write_point(6'(c), 6'(r), pick_coord(), pick_coord(), pick_coord());
   endtask

   // Lets every evaluation in flight come back before registers change.
   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (results_owed != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_reg(input logic [bme_pkg::CSR_IDX_W-1:0] idx,
                          input logic [bme_pkg::CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(input int pu, input int pv, input int wu, input int wv);
      quiesce();
      set_reg(bme_pkg::CSR_POINTS_U, bme_pkg::CSR_DAT_W'(pu));
      set_reg(bme_pkg::CSR_POINTS_V, bme_pkg::CSR_DAT_W'(pv));
      set_reg(bme_pkg::CSR_WRAP_U, bme_pkg::CSR_DAT_W'(wu));
      set_reg(bme_pkg::CSR_WRAP_V, bme_pkg::CSR_DAT_W'(wv));
      span_u = (pu < 2) ? 2 : (pu > GRID_U) ? GRID_U : pu;
      span_v = (pv < 2) ? 2 : (pv > GRID_V) ? GRID_V : pv;
      fill_region();
   endtask

   // Result side: random stalls, none during the steady stretch, and one long
   // hold-off that lets the block back up until it stalls its input.
   initial begin
      int hold_left;
      bit squeezed;
      hold_left = 0;
      squeezed = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_now && !squeezed) begin
            hold_left = 300;
            squeezed = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = !steady && ($urandom_range(99) < 9);
         end
      end
   end

   initial begin
      int ph, n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = bme_pkg::ACTION_WRITE;
      req_column = '0;
      req_row = '0;
      req_point_x = '0;
      req_point_y = '0;
      req_point_z = '0;
      req_param_u = '0;
      req_param_v = '0;
      csr_valid = 1'b0;
      csr_index = bme_pkg::CSR_POINTS_U;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      span_u = 2;
      span_v = 2;

      // Default 2 by 2 open grid with coordinate extremes and other edge values at its corners.
      write_point(6'd0, 6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      write_point(6'd1, 6'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      write_point(6'd0, 6'd1, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000);
      write_point(6'd1, 6'd1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
      evaluate(17'd0, 17'd0);
      evaluate(bme_pkg::ONE_Q16, 17'd0);
      evaluate(17'd0, bme_pkg::ONE_Q16);
      // Parameters of exactly one clamp to the last patch with full fraction.
      evaluate(bme_pkg::ONE_Q16, bme_pkg::ONE_Q16);
      evaluate(17'd32768, 17'd32768);
      evaluate(bme_pkg::ONE_Q16 - 17'd1, 17'd1);
      evaluate(17'd1, bme_pkg::ONE_Q16 - 17'd1);
      // Parameters above one are taken as one.
      evaluate(17'h1_FFFF, 17'h1_0001);

      // Both directions periodic: the far corner of the last patch wraps to 0.
      configure(2, 2, 1, 1);
      evaluate(bme_pkg::ONE_Q16, bme_pkg::ONE_Q16);
      evaluate(17'd32768, 17'd49152);
      evaluate(bme_pkg::ONE_Q16 - 17'd1, bme_pkg::ONE_Q16 - 17'd1);
      evaluate(17'd0, bme_pkg::ONE_Q16);
      // The highest column and row are writable even outside the grid in use.
      write_point(6'd63, 6'd63, pick_coord(), pick_coord(), pick_coord());

      for (ph = 0; ph < 8; ph++) begin
         configure(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2], phase_cfg[ph][3]);
         if (ph == 4)
            steady <= 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 1 && n == 5)
               squeeze_now <= 1'b1;
            if ($urandom_range(99) < 40) begin
               // Half of the writes refresh points that evaluations read.
               if ($urandom_range(1))
                  write_point(6'($urandom_range(span_u - 1)), 6'($urandom_range(span_v - 1)),
                              pick_coord(), pick_coord(), pick_coord());
               else
                  write_point(6'($urandom_range(63)), 6'($urandom_range(63)),
                              pick_coord(), pick_coord(), pick_coord());
            end else begin
               evaluate(pick_param(), pick_param());
            end
         end
         if (ph == 4)
            steady <= 1'b0;
      end

      quiesce();
      if (fail_total == 0 && results_owed == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Guard against a hung handshake; the whole run needs well under a tenth
   // of this.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
